### hdl/hss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hss_pkg;

    // Needle store depth and width of the haystack position counter.
    localparam int NEEDLE_MAX    = 32;
    localparam int POSITION_BITS = 32;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int ALPHABET = 1 << BYTE_W;
    localparam int FUNC_W   = 2;
    localparam int OFFSET_W = 32;
    localparam int LEN_W    = $clog2(NEEDLE_MAX + 1);
    localparam int QCNT_W   = 2;

    typedef logic [BYTE_W-1:0]        t_byte;
    typedef logic [FUNC_W-1:0]        t_func;
    typedef logic [LEN_W-1:0]         t_len;
    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [OFFSET_W-1:0]      t_offset;
    typedef logic [QCNT_W-1:0]        t_qcnt;

    // Input function codes carried on tuser.
    localparam t_func FUNC_NEEDLE   = 2'd0;
    localparam t_func FUNC_HAYSTACK = 2'd1;
    localparam t_func FUNC_RESTART  = 2'd2;

    // Result kinds carried on tuser.
    localparam logic EV_MATCH = 1'b0;
    localparam logic EV_END   = 1'b1;

    // One result transaction.
    typedef struct packed {
        logic    ev;
        t_offset offset;
        logic    last;
    } t_result;

endpackage

`default_nettype wire

### hdl/hss_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hss_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/horspool_substring_search_core.sv
// Needle, restart and unused-function transactions complete on acceptance.
// A haystack byte first has its skip table memory read issued on acceptance,
// then the window compare and countdown update run once the data returns.
// Up to two results wait in a two-entry output queue; a haystack byte stalls
// in its evaluation state only while the queue lacks room for its results.
// Synchronous active-low reset empties the queue and invalidates the skip table.
`timescale 1ns / 1ps
`default_nettype none

module horspool_substring_search_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    input  wire logic        s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] match_offset
    output logic      [0:0]  m_axis_tuser,   // [0] event_res
    output logic             m_axis_tlast    // last_of_run
);

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    t_state r_state, n_state;

    // Search state.
    logic                               r_loading, n_loading;
    hss_pkg::t_len                      r_needle_len, n_needle_len;
    hss_pkg::t_len                      r_fill, n_fill;
    hss_pkg::t_len                      r_countdown, n_countdown;
    hss_pkg::t_pos                      r_pos, n_pos;
    logic [hss_pkg::ALPHABET-1:0]       r_occ_vld, n_occ_vld;
    logic                               r_occ_hit, n_occ_hit;
    logic                               r_fin, n_fin;

    // Needle (newest byte at entry 0) and haystack window (newest at entry 0).
    hss_pkg::t_byte r_needle_sr [hss_pkg::NEEDLE_MAX];
    hss_pkg::t_byte n_needle_sr [hss_pkg::NEEDLE_MAX];
    hss_pkg::t_byte r_window    [hss_pkg::NEEDLE_MAX];
    hss_pkg::t_byte n_window    [hss_pkg::NEEDLE_MAX];

    // Output queue.
    hss_pkg::t_result r_q [2];
    hss_pkg::t_result n_q [2];
    hss_pkg::t_qcnt   r_cnt, n_cnt;

    // Skip table memory.
    logic           ram_we;
    hss_pkg::t_byte ram_waddr;
    hss_pkg::t_len  ram_wdata;
    hss_pkg::t_byte ram_raddr;
    hss_pkg::t_len  ram_rdata;

    logic           in_acc;
    logic           out_acc;
    logic           window_eq;
    hss_pkg::t_len  occ;
    hss_pkg::t_len  skip;
    hss_pkg::t_len  fill_eff;
    hss_pkg::t_len  len_new;
    logic           do_cmp;
    logic           is_match;
    logic [1:0]     n_push;
    logic           go;
    hss_pkg::t_result res [2];
    hss_pkg::t_qcnt cnt_after_pop;
    hss_pkg::t_pos  match_pos;

    hss_ram #(
        .DATA_W (hss_pkg::LEN_W),
        .DEPTH  (hss_pkg::ALPHABET)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_q[0].offset;
    assign m_axis_tuser  = r_q[0].ev;
    assign m_axis_tlast  = r_q[0].last;

    // While a haystack byte waits for queue room, keep reading its own entry.
    assign ram_raddr = (r_state == ST_EVAL) ? r_window[0] : s_axis_tdata;

    // Window against the aligned needle, only over the needle length.
    always_comb begin
        window_eq = 1'b1;
        for (int k = 0; k < hss_pkg::NEEDLE_MAX; k++) begin
            if ((hss_pkg::t_len'(k) < r_needle_len) && (r_needle_sr[k] != r_window[k])) begin
                window_eq = 1'b0;
            end
        end
    end

    // Horspool skip from the last byte of the alignment.
    always_comb begin
        occ = r_occ_hit ? ram_rdata : '0;
        if (occ == '0) begin
            skip = r_needle_len;
        end else if (occ >= r_needle_len) begin
            skip = hss_pkg::t_len'(1);
        end else begin
            skip = r_needle_len - occ;
        end
    end

    // Results of the haystack byte under evaluation.
    always_comb begin
        do_cmp    = (r_needle_len != '0) && (r_countdown == '0);
        is_match  = do_cmp && window_eq;
        match_pos = r_pos - hss_pkg::t_pos'(r_needle_len - hss_pkg::t_len'(1));
        n_push    = {1'b0, is_match} + {1'b0, r_fin};
        res[0]    = '0;
        res[1]    = '0;
        if (is_match) begin
            res[0].ev     = hss_pkg::EV_MATCH;
            res[0].offset = hss_pkg::t_offset'(match_pos);
            res[0].last   = !r_fin;
            res[1].ev     = hss_pkg::EV_END;
            res[1].last   = 1'b1;
        end else begin
            res[0].ev     = hss_pkg::EV_END;
            res[0].last   = 1'b1;
        end
        go = ({1'b0, r_cnt} + {1'b0, n_push}) <= 3'd2;
    end

    // Next-state logic.
    always_comb begin
        n_state      = r_state;
        n_loading    = r_loading;
        n_needle_len = r_needle_len;
        n_fill       = r_fill;
        n_countdown  = r_countdown;
        n_pos        = r_pos;
        n_occ_vld    = r_occ_vld;
        n_occ_hit    = r_occ_hit;
        n_fin        = r_fin;
        n_needle_sr  = r_needle_sr;
        n_window     = r_window;
        ram_we       = 1'b0;
        ram_waddr    = s_axis_tdata;
        fill_eff     = r_loading ? r_fill : '0;
        len_new      = r_needle_len;
        ram_wdata    = fill_eff + hss_pkg::t_len'(1);

        // Output queue: pop the head first, then append.
        n_q[0]        = r_q[0];
        n_q[1]        = r_q[1];
        cnt_after_pop = r_cnt;
        if (out_acc) begin
            n_q[0]        = r_q[1];
            cnt_after_pop = r_cnt - hss_pkg::t_qcnt'(1);
        end
        n_cnt = cnt_after_pop;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_axis_tuser)
                        hss_pkg::FUNC_NEEDLE: begin
                            // A new needle clears the table in one go.
                            if (!r_loading) begin
                                n_occ_vld = '0;
                                n_loading = 1'b1;
                                len_new   = '0;
                            end
                            if (fill_eff < hss_pkg::t_len'(hss_pkg::NEEDLE_MAX)) begin
                                n_needle_sr[0] = s_axis_tdata;
                                for (int k = 1; k < hss_pkg::NEEDLE_MAX; k++) begin
                                    n_needle_sr[k] = r_needle_sr[k-1];
                                end
                                if (!s_axis_tlast) begin
                                    ram_we                  = 1'b1;
                                    n_occ_vld[s_axis_tdata] = 1'b1;
                                end
                                n_fill = fill_eff + hss_pkg::t_len'(1);
                                if (s_axis_tlast) begin
                                    len_new = fill_eff + hss_pkg::t_len'(1);
                                end
                            end else begin
                                n_fill = fill_eff;
                                if (s_axis_tlast) begin
                                    len_new = '0;
                                end
                            end
                            if (s_axis_tlast) begin
                                n_loading = 1'b0;
                            end
                            n_needle_len = len_new;
                            n_pos        = '0;
                            n_countdown  = (len_new != '0) ? len_new - hss_pkg::t_len'(1) : '0;
                        end
                        hss_pkg::FUNC_HAYSTACK: begin
                            n_window[0] = s_axis_tdata;
                            for (int k = 1; k < hss_pkg::NEEDLE_MAX; k++) begin
                                n_window[k] = r_window[k-1];
                            end
                            n_occ_hit = r_occ_vld[s_axis_tdata];
                            n_fin     = s_axis_tlast;
                            n_state   = ST_EVAL;
                        end
                        hss_pkg::FUNC_RESTART: begin
                            n_pos       = '0;
                            n_countdown = (r_needle_len != '0) ?
                                          r_needle_len - hss_pkg::t_len'(1) : '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                if (go) begin
                    if (r_needle_len != '0) begin
                        if (r_countdown == '0) begin
                            if (is_match) begin
                                n_countdown = r_needle_len - hss_pkg::t_len'(1);
                            end else begin
                                n_countdown = skip - hss_pkg::t_len'(1);
                            end
                        end else begin
                            n_countdown = r_countdown - hss_pkg::t_len'(1);
                        end
                    end
                    if (r_pos != '1) begin
                        n_pos = r_pos + hss_pkg::t_pos'(1);
                    end
                    if (r_fin) begin
                        n_pos       = '0;
                        n_countdown = (r_needle_len != '0) ?
                                      r_needle_len - hss_pkg::t_len'(1) : '0;
                    end
                    // Append the results behind whatever is still queued.
                    if (n_push != 2'd0) begin
                        n_q[cnt_after_pop[0]] = res[0];
                    end
                    if (n_push == 2'd2) begin
                        n_q[1] = res[1];
                    end
                    n_cnt   = cnt_after_pop + hss_pkg::t_qcnt'(n_push);
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_loading    <= 1'b0;
            r_needle_len <= '0;
            r_fill       <= '0;
            r_countdown  <= '0;
            r_pos        <= '0;
            r_occ_vld    <= '0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_loading    <= n_loading;
            r_needle_len <= n_needle_len;
            r_fill       <= n_fill;
            r_countdown  <= n_countdown;
            r_pos        <= n_pos;
            r_occ_vld    <= n_occ_vld;
            r_cnt        <= n_cnt;
        end
        r_occ_hit   <= n_occ_hit;
        r_fin       <= n_fin;
        r_needle_sr <= n_needle_sr;
        r_window    <= n_window;
        r_q         <= n_q;
    end

endmodule

`default_nettype wire
